@@ design/swts_pkg.sv @@
// Shared types and constants for the square-wave tone sequencer.
package swts_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int MAX_LEVEL   = 200;
    localparam int LEVEL_STEP  = 10;
    localparam int RESET_LEVEL = 100;

    localparam int LEVEL_W     = 8;
    localparam int PERIOD_W    = 16;
    localparam int DUR_W       = 24;
    localparam int POS_W       = 9;
    localparam int BASE_W      = 8;
    localparam int SUM_W       = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

    localparam int REG_ADDR_W  = 3;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_VOL_DOWN = 3'd1,
        CMD_VOL_UP   = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_START    = 3'd4
    } t_cmd;

    typedef enum logic {
        REG_SONG_BASE   = 1'b0,
        REG_SONG_LENGTH = 1'b1
    } t_reg;

endpackage

@@ design/swts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/square_wave_tone_sequencer.sv @@
// Square-wave tone sequencer: tone table RAMs, song timer and sample generator.
//
// The block plays a song held in a tone table of TABLE_DEPTH entries (period
// and duration, both in sample ticks) as a square wave. Each input
// transaction carries a command in tuser: tick, volume down, volume up, write
// tone entry or start song; each one yields exactly one result transaction.
// The table lives in registered-read RAMs, so the entries the next tick may
// need (duration of the current tone, period of the next tone and period of
// the first tone) are fetched ahead of time. While a tone keeps playing, or
// for volume commands and ticks while stopped, one transaction is taken every
// cycle. A transaction that writes the table, starts the song or ends a tone,
// and any register write, changes what must be fetched, so the input holds
// tready low after it while the RAMs are read again. The result sits in an
// output register, so a new input can be taken in the same cycle that the
// previous result leaves; while the downstream side stalls a waiting result,
// tready stays low. Program song_base and song_length over the APB port only
// while the block is idle.
module square_wave_tone_sequencer
    import swts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [REG_ADDR_W-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: tone_index[7:0], tone_period[23:8], tone_duration[47:24]
    input  logic [47:0]            s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [2:0]             s_axis_tuser,

    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: sample[7:0], playing[8], volume_level[16:9], zero pad[23:17]
    output logic [23:0]            m_axis_tdata,
    // tuser: sample_written[0]
    output logic                   m_axis_tuser,
    // tlast: song_finished
    output logic                   m_axis_tlast
);

    // configuration registers
    logic [BASE_W-1:0]   r_song_base;
    logic [POS_W-1:0]    r_song_length;

    // sequencer state
    logic [PERIOD_W-1:0] r_half_cnt,  n_half_cnt;
    logic [DUR_W-1:0]    r_tick_cnt,  n_tick_cnt;
    logic [POS_W-1:0]    r_pos,       n_pos;
    logic [PERIOD_W-1:0] r_active,    n_active;
    logic                r_level_high, n_level_high;
    logic [LEVEL_W-1:0]  r_amp,       n_amp;
    logic                r_running,   n_running;
    logic                r_pf_valid,  n_pf_valid;

    // result register
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_out_sample,  n_sample;
    logic                r_out_written, n_written;
    logic                r_out_playing;
    logic                r_out_finished, n_finished;
    logic [LEVEL_W-1:0]  r_out_volume;

    logic                w_cfg_wr;
    logic                w_accept;
    logic                w_tone_move;
    t_cmd                w_cmd;

    logic [POS_W-1:0]    w_pos_inc;
    logic                w_wrap;
    logic [ADDR_W-1:0]   w_addr_cur;
    logic [ADDR_W-1:0]   w_addr_next;
    logic [ADDR_W-1:0]   w_addr_first;
    logic [ADDR_W-1:0]   w_waddr;
    logic                w_we;

    logic [DUR_W-1:0]    w_cur_dur;
    logic [PERIOD_W-1:0] w_next_per;
    logic [PERIOD_W-1:0] w_first_per;
    logic [LEVEL_W:0]    w_amp_up;

    // ------------------------------------------------------------------
    // APB register file; pready is always high
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg'(paddr[2]))
            REG_SONG_BASE:   prdata = 32'(r_song_base);
            REG_SONG_LENGTH: prdata = 32'(r_song_length);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_base   <= '0;
            r_song_length <= POS_W'(1);
        end else if (w_cfg_wr) begin
            case (t_reg'(paddr[2]))
                REG_SONG_BASE:   r_song_base   <= pwdata[BASE_W-1:0];
                REG_SONG_LENGTH: r_song_length <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Table addressing: entry played is (base + position) mod depth
    // ------------------------------------------------------------------
    assign w_pos_inc    = r_pos + POS_W'(1);
    assign w_wrap       = (w_pos_inc >= r_song_length);
    assign w_addr_cur   = ADDR_W'(SUM_W'(r_song_base) + SUM_W'(r_pos));
    assign w_addr_next  = ADDR_W'(SUM_W'(r_song_base) + SUM_W'(w_pos_inc));
    assign w_addr_first = ADDR_W'(r_song_base);

    assign w_cmd   = t_cmd'(s_axis_tuser);
    assign w_we    = w_accept && (w_cmd == CMD_WRITE);
    assign w_waddr = ADDR_W'(s_axis_tdata[7:0]);

    // duration of the tone now playing
    swts_ram #(.WIDTH(DUR_W), .DEPTH(TABLE_DEPTH)) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[47:24]),
        .i_raddr (w_addr_cur),
        .o_rdata (w_cur_dur)
    );

    // period of the tone that follows
    swts_ram #(.WIDTH(PERIOD_W), .DEPTH(TABLE_DEPTH)) u_next_per_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[23:8]),
        .i_raddr (w_addr_next),
        .o_rdata (w_next_per)
    );

    // period of the first tone, for start and for the wrap at song end
    swts_ram #(.WIDTH(PERIOD_W), .DEPTH(TABLE_DEPTH)) u_first_per_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[23:8]),
        .i_raddr (w_addr_first),
        .o_rdata (w_first_per)
    );

    // ------------------------------------------------------------------
    // Handshake: take an item once the prefetched entries are current and
    // the result register is free or being drained
    // ------------------------------------------------------------------
    assign s_axis_tready = r_pf_valid && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_amp_up = (LEVEL_W+1)'(r_amp) + (LEVEL_W+1)'(LEVEL_STEP);

    always_comb begin
        n_half_cnt   = r_half_cnt;
        n_tick_cnt   = r_tick_cnt;
        n_pos        = r_pos;
        n_active     = r_active;
        n_level_high = r_level_high;
        n_amp        = r_amp;
        n_running    = r_running;
        n_sample     = '0;
        n_written    = 1'b0;
        n_finished   = 1'b0;
        w_tone_move  = 1'b0;

        case (w_cmd)
            CMD_TICK: begin
                if (r_running) begin
                    n_tick_cnt = r_tick_cnt + DUR_W'(1);
                    // advance to the next tone once the duration is reached
                    if (n_tick_cnt >= w_cur_dur) begin
                        w_tone_move = 1'b1;
                        n_tick_cnt  = '0;
                        if (w_wrap) begin
                            n_pos      = '0;
                            n_running  = 1'b0;
                            n_finished = 1'b1;
                            n_active   = w_first_per;
                        end else begin
                            n_pos      = w_pos_inc;
                            n_active   = w_next_per;
                        end
                    end
                    // emit a sample and toggle every half period
                    if (n_active != '0) begin
                        n_sample   = r_level_high ? r_amp : '0;
                        n_written  = 1'b1;
                        n_half_cnt = r_half_cnt + PERIOD_W'(1);
                        if (n_half_cnt >= (n_active >> 1)) begin
                            n_level_high = ~r_level_high;
                            n_half_cnt   = '0;
                        end
                    end
                end
            end
            CMD_VOL_DOWN: begin
                n_amp = (r_amp < LEVEL_W'(LEVEL_STEP)) ? '0 : r_amp - LEVEL_W'(LEVEL_STEP);
            end
            CMD_VOL_UP: begin
                n_amp = (w_amp_up > (LEVEL_W+1)'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                             : w_amp_up[LEVEL_W-1:0];
            end
            CMD_WRITE: ;
            CMD_START: begin
                n_half_cnt = '0;
                n_tick_cnt = '0;
                n_pos      = '0;
                n_active   = w_first_per;
                n_running  = 1'b1;
            end
            default: ;
        endcase

        // drop the prefetch whenever the table, the window or the position moves
        n_pf_valid = !(w_cfg_wr ||
                       (w_accept && ((w_cmd == CMD_WRITE) || (w_cmd == CMD_START) ||
                                     w_tone_move)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_cnt   <= '0;
            r_tick_cnt   <= '0;
            r_pos        <= '0;
            r_active     <= '0;
            r_level_high <= 1'b0;
            r_amp        <= LEVEL_W'(RESET_LEVEL);
            r_running    <= 1'b0;
            r_pf_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pf_valid <= n_pf_valid;
            if (w_accept) begin
                r_half_cnt   <= n_half_cnt;
                r_tick_cnt   <= n_tick_cnt;
                r_pos        <= n_pos;
                r_active     <= n_active;
                r_level_high <= n_level_high;
                r_amp        <= n_amp;
                r_running    <= n_running;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload: load on each accepted transaction, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_sample   <= n_sample;
            r_out_written  <= n_written;
            r_out_playing  <= n_running;
            r_out_finished <= n_finished;
            r_out_volume   <= n_amp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_volume, r_out_playing, r_out_sample};
    assign m_axis_tuser  = r_out_written;
    assign m_axis_tlast  = r_out_finished;

endmodule
